### src/polymer_chain_length_stats_defines.svh
// Assertion macros shared by the polymer chain statistics design.
`ifndef POLYMER_CHAIN_LENGTH_STATS_DEFINES_SVH
`define POLYMER_CHAIN_LENGTH_STATS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PCLS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PCLS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/pcls_pkg.sv
// Package with the types, constants and helpers of the chain statistics block.
`default_nettype none
package pcls_pkg;

  localparam int MAX_CHAIN_LENGTH_DEF = 256;
  localparam int CHAIN_LENGTH_RESET   = 16;
  localparam int CHAIN_COUNT_RESET    = 1;
  localparam int CFG_W                = 16;

  typedef enum logic [0:0] {
    REG_CHAIN_LENGTH = 1'b0,
    REG_CHAIN_COUNT  = 1'b1
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_ACC, ST_LEND, ST_DIV, ST_DWAIT, ST_GRD, ST_GLD,
    ST_CEND, ST_TOT, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_BOND, PH_END, PH_GYR
  } phase_t;

  typedef enum logic [3:0] {
    DV_CX, DV_CY, DV_CZ, DV_BM, DV_GM, DV_EM, DV_RB, DV_RG, DV_RE
  } div_sel_t;

  typedef struct packed {
    logic     accept;
    logic     end_load;
    logic     mem_rd;
    logic     gyr_load;
    logic     gidx_clr;
    logic     gidx_inc;
    logic     sq_run;
    logic [1:0] comp;
    logic     acc_en;
    phase_t   acc_sel;
    logic     div_start;
    div_sel_t div_sel;
    logic     chain_end;
    logic     totals;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic bead_first;
    logic bead_last;
    logic chain_last;
    logic gidx_last;
    logic div_busy;
    logic div_done;
    logic out_free;
  } status_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

endpackage
`default_nettype wire

### src/pcls_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
`default_nettype none
module pcls_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [63:0]      quotient
);

  logic [63:0] num;
  logic [31:0] den;
  logic [31:0] rem;
  logic [5:0]  cnt;
  logic [32:0] rem_sh;
  logic        ge;
  logic [32:0] rem_sub;

  always_comb begin
    rem_sh  = {rem, num[63]};
    ge      = rem_sh >= {1'b0, den};
    rem_sub = rem_sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      rem <= '0;
      cnt <= '0;
    end else if (busy) begin
      num <= {num[62:0], ge};
      rem <= ge ? rem_sub[31:0] : rem_sh[31:0];
      cnt <= cnt + 6'd1;
    end
  end

  assign quotient = num;

endmodule
`default_nettype wire

### src/pcls_dp.sv
// Datapath: chain store, squarer, accumulators, shared divider and result register.
`default_nettype none
module pcls_dp #(
  parameter int MAX_CHAIN_LENGTH = pcls_pkg::MAX_CHAIN_LENGTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire pcls_pkg::cmd_t          cmd,
  output pcls_pkg::status_t            st,
  input  wire logic                    wr_en,
  input  wire logic                    wr_index,
  input  wire logic [pcls_pkg::CFG_W-1:0] wr_data,
  input  wire logic signed [31:0]      bead_x,
  input  wire logic signed [31:0]      bead_y,
  input  wire logic signed [31:0]      bead_z,
  input  wire logic [31:0]             frame_step,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [31:0]                  step_label,
  output logic [63:0]                  bond_sq_mean,
  output logic [63:0]                  bond_sq_running,
  output logic [63:0]                  gyration_sq_mean,
  output logic [63:0]                  gyration_sq_running,
  output logic [63:0]                  end_sq_mean,
  output logic [63:0]                  end_sq_running
);

  localparam int AW = $clog2(MAX_CHAIN_LENGTH);
  localparam int LW = $clog2(MAX_CHAIN_LENGTH + 1);
  localparam int PW = LW + 16;
  // A chain sum holds up to 2^AW signed 32-bit coordinates.
  localparam int SW = AW + 32;

  logic [8:0]  chain_length;
  logic [15:0] chain_count;
  logic [LW-1:0] len_eff;
  logic [15:0]   cnt_eff;

  logic [95:0] mem [MAX_CHAIN_LENGTH];
  logic [95:0] rdata;

  logic signed [31:0] prev_x, prev_y, prev_z;
  logic signed [31:0] first_x, first_y, first_z;
  logic signed [31:0] cur_x, cur_y, cur_z;
  logic signed [SW-1:0] sum_x, sum_y, sum_z;
  logic signed [32:0] cx, cy, cz;
  logic signed [33:0] d0, d1, d2, dsel, dmag;
  logic [63:0] prod, dsum;
  logic [63:0] frame_bond_acc, frame_gyration_acc, frame_end_acc;
  logic [63:0] total_bond, total_gyration, total_end;
  logic [63:0] bm, gm, em, rb, rg, re;
  logic [31:0] frames_done;
  logic [AW-1:0] bead_position, gidx;
  logic [15:0] chain_position;
  logic [31:0] step_latch;

  logic [63:0] div_dividend, div_quotient;
  logic [31:0] div_divisor;
  logic        div_busy, div_done, div_neg, sum_neg;
  logic [SW-1:0] sum_sel;
  pcls_pkg::div_sel_t div_sel_q;
  logic [PW-1:0] bond_den, gyr_den;
  logic [32:0] cres;
  logic        restart;

  always_comb begin
    if (chain_length < 9'd2) begin
      len_eff = LW'(2);
    end else if (32'(chain_length) > 32'(MAX_CHAIN_LENGTH)) begin
      len_eff = LW'(MAX_CHAIN_LENGTH);
    end else begin
      len_eff = LW'(chain_length);
    end
    cnt_eff  = (chain_count == 16'd0) ? 16'd1 : chain_count;
    bond_den = PW'(len_eff - LW'(1)) * PW'(cnt_eff);
    gyr_den  = PW'(len_eff) * PW'(cnt_eff);
  end

  assign st.bead_first = (bead_position == '0);
  assign st.bead_last  = (LW'(bead_position) == len_eff - LW'(1));
  assign st.chain_last = (chain_position == cnt_eff - 16'd1);
  assign st.gidx_last  = (LW'(gidx) == len_eff - LW'(1));
  assign st.div_busy   = div_busy;
  assign st.div_done   = div_done;
  assign st.out_free   = !out_valid || !out_stall;

  assign restart = wr_en;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_length <= 9'(pcls_pkg::CHAIN_LENGTH_RESET);
      chain_count  <= 16'(pcls_pkg::CHAIN_COUNT_RESET);
    end else if (wr_en) begin
      case (pcls_pkg::reg_index_t'(wr_index))
        pcls_pkg::REG_CHAIN_LENGTH: chain_length <= wr_data[8:0];
        pcls_pkg::REG_CHAIN_COUNT:  chain_count  <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  // Chain store.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[bead_position] <= {bead_z, bead_y, bead_x};
    end
    if (cmd.mem_rd) begin
      rdata <= mem[gidx];
    end
  end

  // Difference registers and squarer.
  always_comb begin
    case (cmd.comp)
      2'd0:    dsel = d0;
      2'd1:    dsel = d1;
      default: dsel = d2;
    endcase
    dmag = dsel[33] ? -dsel : dsel;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      d0 <= 34'(bead_x) - 34'(prev_x);
      d1 <= 34'(bead_y) - 34'(prev_y);
      d2 <= 34'(bead_z) - 34'(prev_z);
    end else if (cmd.end_load) begin
      d0 <= 34'(first_x) - 34'(cur_x);
      d1 <= 34'(first_y) - 34'(cur_y);
      d2 <= 34'(first_z) - 34'(cur_z);
    end else if (cmd.gyr_load) begin
      d0 <= 34'(signed'(rdata[31:0]))  - 34'(cx);
      d1 <= 34'(signed'(rdata[63:32])) - 34'(cy);
      d2 <= 34'(signed'(rdata[95:64])) - 34'(cz);
    end
    if (cmd.sq_run) begin
      if (cmd.comp != 2'd3) begin
        prod <= dmag[31:0] * dmag[31:0];
      end
      dsum <= (cmd.comp == 2'd0) ? 64'd0 : pcls_pkg::sat_add(dsum, prod);
    end
  end

  // Bead registers, chain sums, positions and frame accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x <= '0; prev_y <= '0; prev_z <= '0;
      first_x <= '0; first_y <= '0; first_z <= '0;
      step_latch <= '0;
    end else if (cmd.accept) begin
      prev_x <= bead_x; prev_y <= bead_y; prev_z <= bead_z;
      if (bead_position == '0) begin
        first_x <= bead_x; first_y <= bead_y; first_z <= bead_z;
        if (chain_position == 16'd0) begin
          step_latch <= frame_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_x <= bead_x; cur_y <= bead_y; cur_z <= bead_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      bead_position      <= '0;
      chain_position     <= '0;
      sum_x <= '0; sum_y <= '0; sum_z <= '0;
      frame_bond_acc     <= '0;
      frame_gyration_acc <= '0;
      frame_end_acc      <= '0;
    end else begin
      if (cmd.accept) begin
        sum_x <= sum_x + SW'(bead_x);
        sum_y <= sum_y + SW'(bead_y);
        sum_z <= sum_z + SW'(bead_z);
        if (!st.bead_last) begin
          bead_position <= bead_position + AW'(1);
        end
      end
      if (cmd.acc_en) begin
        case (cmd.acc_sel)
          pcls_pkg::PH_BOND: frame_bond_acc <= pcls_pkg::sat_add(frame_bond_acc, dsum);
          pcls_pkg::PH_END:  frame_end_acc  <= pcls_pkg::sat_add(frame_end_acc, dsum);
          default: frame_gyration_acc <= pcls_pkg::sat_add(frame_gyration_acc, dsum);
        endcase
      end
      if (cmd.chain_end) begin
        sum_x <= '0; sum_y <= '0; sum_z <= '0;
        bead_position  <= '0;
        chain_position <= st.chain_last ? 16'd0 : chain_position + 16'd1;
      end
      if (cmd.out_load) begin
        frame_bond_acc     <= '0;
        frame_gyration_acc <= '0;
        frame_end_acc      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gidx_clr) begin
      gidx <= '0;
    end else if (cmd.gidx_inc) begin
      gidx <= gidx + AW'(1);
    end
  end

  // Shared divider and its operand selection.
  always_comb begin
    case (cmd.div_sel)
      pcls_pkg::DV_CX: sum_sel = sum_x;
      pcls_pkg::DV_CY: sum_sel = sum_y;
      default:         sum_sel = sum_z;
    endcase
    sum_neg = sum_sel[SW-1];
    div_dividend = 64'(sum_neg ? -sum_sel : sum_sel);
    div_divisor  = 32'(len_eff);
    case (cmd.div_sel)
      pcls_pkg::DV_CX, pcls_pkg::DV_CY, pcls_pkg::DV_CZ: ;
      pcls_pkg::DV_BM: begin
        div_dividend = frame_bond_acc;
        div_divisor  = 32'(bond_den);
      end
      pcls_pkg::DV_GM: begin
        div_dividend = frame_gyration_acc;
        div_divisor  = 32'(gyr_den);
      end
      pcls_pkg::DV_EM: begin
        div_dividend = frame_end_acc;
        div_divisor  = 32'(cnt_eff);
      end
      pcls_pkg::DV_RB: begin
        div_dividend = total_bond;
        div_divisor  = frames_done;
      end
      pcls_pkg::DV_RG: begin
        div_dividend = total_gyration;
        div_divisor  = frames_done;
      end
      default: begin
        div_dividend = total_end;
        div_divisor  = frames_done;
      end
    endcase
  end

  pcls_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign cres = div_neg ? -div_quotient[32:0] : div_quotient[32:0];

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_sel_q <= cmd.div_sel;
      div_neg   <= sum_neg;
    end
    if (div_done) begin
      case (div_sel_q)
        pcls_pkg::DV_CX: cx <= cres;
        pcls_pkg::DV_CY: cy <= cres;
        pcls_pkg::DV_CZ: cz <= cres;
        pcls_pkg::DV_BM: bm <= div_quotient;
        pcls_pkg::DV_GM: gm <= div_quotient;
        pcls_pkg::DV_EM: em <= div_quotient;
        pcls_pkg::DV_RB: rb <= div_quotient;
        pcls_pkg::DV_RG: rg <= div_quotient;
        default:         re <= div_quotient;
      endcase
    end
  end

  // Running totals.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_bond     <= '0;
      total_gyration <= '0;
      total_end      <= '0;
      frames_done    <= '0;
    end else if (cmd.totals) begin
      total_bond     <= pcls_pkg::sat_add(total_bond, bm);
      total_gyration <= pcls_pkg::sat_add(total_gyration, gm);
      total_end      <= pcls_pkg::sat_add(total_end, em);
      if (frames_done != '1) begin
        frames_done <= frames_done + 32'd1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      step_label          <= step_latch;
      bond_sq_mean        <= bm;
      bond_sq_running     <= rb;
      gyration_sq_mean    <= gm;
      gyration_sq_running <= rg;
      end_sq_mean         <= em;
      end_sq_running      <= re;
    end
  end

endmodule
`default_nettype wire

### src/pcls_ctrl.sv
// Controller state machine that sequences the datapath for each bead.
`default_nettype none
`include "polymer_chain_length_stats_defines.svh"
module pcls_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pcls_pkg::status_t st,
  output pcls_pkg::cmd_t         cmd
);

  pcls_pkg::state_t   state, state_next;
  pcls_pkg::phase_t   phase, phase_next;
  pcls_pkg::div_sel_t div_sel, div_sel_next;
  logic [1:0] comp, comp_next;
  logic       last_q, last_q_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pcls_pkg::ST_IDLE;
      phase   <= pcls_pkg::PH_BOND;
      div_sel <= pcls_pkg::DV_CX;
      comp    <= 2'd0;
      last_q  <= 1'b0;
    end else begin
      state   <= state_next;
      phase   <= phase_next;
      div_sel <= div_sel_next;
      comp    <= comp_next;
      last_q  <= last_q_next;
    end
  end

  always_comb begin
    state_next   = state;
    phase_next   = phase;
    div_sel_next = div_sel;
    comp_next    = comp;
    last_q_next  = last_q;
    in_stall     = 1'b1;
    cmd          = '0;
    cmd.comp     = comp;
    cmd.acc_sel  = phase;
    cmd.div_sel  = div_sel;
    case (state)
      pcls_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept  = 1'b1;
          last_q_next = st.bead_last;
          phase_next  = pcls_pkg::PH_BOND;
          comp_next   = 2'd0;
          state_next  = st.bead_first ? pcls_pkg::ST_IDLE : pcls_pkg::ST_SQ;
        end
      end
      pcls_pkg::ST_SQ: begin
        cmd.sq_run = 1'b1;
        comp_next  = comp + 2'd1;
        if (comp == 2'd3) begin
          state_next = pcls_pkg::ST_ACC;
        end
      end
      pcls_pkg::ST_ACC: begin
        cmd.acc_en = 1'b1;
        case (phase)
          pcls_pkg::PH_BOND: begin
            state_next = last_q ? pcls_pkg::ST_LEND : pcls_pkg::ST_IDLE;
          end
          pcls_pkg::PH_END: begin
            div_sel_next = pcls_pkg::DV_CX;
            state_next   = pcls_pkg::ST_DIV;
          end
          default: begin
            if (st.gidx_last) begin
              state_next = pcls_pkg::ST_CEND;
            end else begin
              cmd.gidx_inc = 1'b1;
              state_next   = pcls_pkg::ST_GRD;
            end
          end
        endcase
      end
      pcls_pkg::ST_LEND: begin
        cmd.end_load = 1'b1;
        phase_next   = pcls_pkg::PH_END;
        comp_next    = 2'd0;
        state_next   = pcls_pkg::ST_SQ;
      end
      pcls_pkg::ST_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = pcls_pkg::ST_DWAIT;
      end
      pcls_pkg::ST_DWAIT: begin
        if (st.div_done) begin
          state_next = pcls_pkg::ST_DIV;
          case (div_sel)
            pcls_pkg::DV_CX: div_sel_next = pcls_pkg::DV_CY;
            pcls_pkg::DV_CY: div_sel_next = pcls_pkg::DV_CZ;
            pcls_pkg::DV_CZ: begin
              cmd.gidx_clr = 1'b1;
              state_next   = pcls_pkg::ST_GRD;
            end
            pcls_pkg::DV_BM: div_sel_next = pcls_pkg::DV_GM;
            pcls_pkg::DV_GM: div_sel_next = pcls_pkg::DV_EM;
            pcls_pkg::DV_EM: state_next   = pcls_pkg::ST_TOT;
            pcls_pkg::DV_RB: div_sel_next = pcls_pkg::DV_RG;
            pcls_pkg::DV_RG: div_sel_next = pcls_pkg::DV_RE;
            default:         state_next   = pcls_pkg::ST_OUT;
          endcase
        end
      end
      pcls_pkg::ST_GRD: begin
        cmd.mem_rd = 1'b1;
        state_next = pcls_pkg::ST_GLD;
      end
      pcls_pkg::ST_GLD: begin
        cmd.gyr_load = 1'b1;
        phase_next   = pcls_pkg::PH_GYR;
        comp_next    = 2'd0;
        state_next   = pcls_pkg::ST_SQ;
      end
      pcls_pkg::ST_CEND: begin
        cmd.chain_end = 1'b1;
        if (st.chain_last) begin
          div_sel_next = pcls_pkg::DV_BM;
          state_next   = pcls_pkg::ST_DIV;
        end else begin
          state_next = pcls_pkg::ST_IDLE;
        end
      end
      pcls_pkg::ST_TOT: begin
        cmd.totals   = 1'b1;
        div_sel_next = pcls_pkg::DV_RB;
        state_next   = pcls_pkg::ST_DIV;
      end
      pcls_pkg::ST_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = pcls_pkg::ST_IDLE;
        end
      end
      default: state_next = pcls_pkg::ST_IDLE;
    endcase
  end

  `PCLS_ASSERT_NOW(a_div_idle, clk, rst, cmd.div_start, !st.div_busy, "divider started while busy")
  `PCLS_ASSERT_NEXT(a_div_runs, clk, rst, cmd.div_start, st.div_busy, "divider did not start")
  `PCLS_ASSERT_NOW(a_out_free, clk, rst, cmd.out_load, st.out_free, "result overwritten")

endmodule
`default_nettype wire

### src/polymer_chain_length_stats.sv
// Top level of the polymer chain length statistics block.
//
//  channel   direction  handshake               payload
//  in        input      in_valid / in_stall     bead_x, bead_y, bead_z, frame_step
//  out       output     out_valid / out_stall   step_label and six unsigned Q64.0 statistics
//  config    input      wr_en                   wr_index, wr_data
//
// A bead that is not the first of its chain has its bond square formed and
// accumulated; the first bead of a chain is only stored.
// The last bead of a chain adds the end-to-end square, 3 center-of-mass
// divisions, a gyration pass that reads the chain store once per stored bead,
// and a step that closes the chain.
// The last bead of a frame adds 6 divisions on the one shared divider: the
// 3 frame means, then, after the running totals update, the 3 running means;
// a final step loads the result.
// Reset is synchronous and needs no clearing pass.
// A stalled result waits in the output register; the block stalls its input
// whenever it is not idle, also while a new result waits for the old one.
`default_nettype none
module polymer_chain_length_stats #(
  parameter int MAX_CHAIN_LENGTH = pcls_pkg::MAX_CHAIN_LENGTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic                       wr_index,
  input  wire logic [pcls_pkg::CFG_W-1:0] wr_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [31:0]         bead_x,
  input  wire logic signed [31:0]         bead_y,
  input  wire logic signed [31:0]         bead_z,
  input  wire logic [31:0]                frame_step,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [31:0]                     step_label,
  output logic [63:0]                     bond_sq_mean,
  output logic [63:0]                     bond_sq_running,
  output logic [63:0]                     gyration_sq_mean,
  output logic [63:0]                     gyration_sq_running,
  output logic [63:0]                     end_sq_mean,
  output logic [63:0]                     end_sq_running
);

  // The controller steps through each bead; the datapath does the arithmetic.
  pcls_pkg::cmd_t    cmd;
  pcls_pkg::status_t st;

  pcls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  pcls_dp #(
    .MAX_CHAIN_LENGTH (MAX_CHAIN_LENGTH)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .st                  (st),
    .wr_en               (wr_en),
    .wr_index            (wr_index),
    .wr_data             (wr_data),
    .bead_x              (bead_x),
    .bead_y              (bead_y),
    .bead_z              (bead_z),
    .frame_step          (frame_step),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .step_label          (step_label),
    .bond_sq_mean        (bond_sq_mean),
    .bond_sq_running     (bond_sq_running),
    .gyration_sq_mean    (gyration_sq_mean),
    .gyration_sq_running (gyration_sq_running),
    .end_sq_mean         (end_sq_mean),
    .end_sq_running      (end_sq_running)
  );

endmodule
`default_nettype wire
